// ===== hw/rtl/tbbc_pkg.sv =====
`default_nettype none

package tbbc_pkg;

    // Fixed field widths
    localparam int COORD_W  = 17;   // signed box corner
    localparam int EXTENT_W = 16;   // box width / height
    localparam int BORDER_W = 11;
    localparam int SIZE_W   = 13;

    // Configuration port
    localparam int APB_ADDR_W = 5;
    localparam int APB_DATA_W = 32;

    // Parameter defaults
    localparam int DEF_MAX_TILES_PER_AXIS = 16;
    localparam int DEF_MAX_BOXES_PER_TILE = 4096;

    // Register reset values
    localparam logic [BORDER_W-1:0] RST_BORDER = '0;
    localparam logic [SIZE_W-1:0]   RST_SIZE   = SIZE_W'(4096);
    localparam int                  RST_COUNT  = 1;

    // Register indexes (byte address / 4)
    typedef enum logic [2:0] {
        REG_SEAM_HALF_X     = 3'd0,
        REG_SEAM_HALF_Y     = 3'd1,
        REG_TILE_WIDTH      = 3'd2,
        REG_TILE_HEIGHT     = 3'd3,
        REG_LAST_COL_WIDTH  = 3'd4,
        REG_LAST_ROW_HEIGHT = 3'd5,
        REG_TILES_ACROSS    = 3'd6,
        REG_TILES_DOWN      = 3'd7
    } tbbc_reg_t;

    // Tile geometry handed to the seam check
    typedef struct packed {
        logic [BORDER_W-1:0] seam_half_x;
        logic [BORDER_W-1:0] seam_half_y;
        logic [SIZE_W-1:0]   tile_width;
        logic [SIZE_W-1:0]   tile_height;
        logic [SIZE_W-1:0]   last_col_width;
        logic [SIZE_W-1:0]   last_row_height;
    } tbbc_geom_t;

endpackage

`default_nettype wire

// ===== hw/rtl/tbbc_seam_check.sv =====
`default_nettype none

module tbbc_seam_check
    import tbbc_pkg::*;
#(
    parameter int TILE_IDX_W = 4,
    parameter int COUNT_W    = 5
)
(
    input  wire tbbc_geom_t                  geom,
    input  wire logic [COUNT_W-1:0]          tiles_across,
    input  wire logic [COUNT_W-1:0]          tiles_down,
    input  wire logic [TILE_IDX_W-1:0]       tile_row,
    input  wire logic [TILE_IDX_W-1:0]       tile_col,
    input  wire logic signed [COORD_W-1:0]   box_x,
    input  wire logic signed [COORD_W-1:0]   box_y,
    input  wire logic [EXTENT_W-1:0]         box_width,
    input  wire logic [EXTENT_W-1:0]         box_height,
    output logic                             hit
);

    localparam int PROD_W = SIZE_W + TILE_IDX_W;
    localparam int BASE_W = (PROD_W > COORD_W + 1) ? PROD_W : COORD_W + 1;
    localparam int CW     = BASE_W + 3;
    localparam int CMP_W  = ((TILE_IDX_W > COUNT_W) ? TILE_IDX_W : COUNT_W) + 1;

    logic              last_col, last_row;
    logic [SIZE_W-1:0] tw, th;
    logic [PROD_W-1:0] ox_u, oy_u;

    logic signed [CW-1:0] ox, oy, bx, by, tws, ths;
    logic signed [CW-1:0] x0, y0, x1, y1;
    logic signed [CW-1:0] xa, xb, xc, xd, ya, yb, yc, yd;
    logic top_hit, left_hit, right_hit, bottom_hit;

    // last column / row use their own sizes
    assign last_col = (CMP_W'(tile_col) + CMP_W'(1)) == CMP_W'(tiles_across);
    assign last_row = (CMP_W'(tile_row) + CMP_W'(1)) == CMP_W'(tiles_down);
    assign tw = last_col ? geom.last_col_width  : geom.tile_width;
    assign th = last_row ? geom.last_row_height : geom.tile_height;

    // tile origin in the image
    assign ox_u = PROD_W'(geom.tile_width)  * PROD_W'(tile_col);
    assign oy_u = PROD_W'(geom.tile_height) * PROD_W'(tile_row);

    assign ox  = $signed(CW'(ox_u));
    assign oy  = $signed(CW'(oy_u));
    assign bx  = $signed(CW'(geom.seam_half_x));
    assign by  = $signed(CW'(geom.seam_half_y));
    assign tws = $signed(CW'(tw));
    assign ths = $signed(CW'(th));

    // box corners
    assign x0 = CW'(box_x);
    assign y0 = CW'(box_y);
    assign x1 = x0 + $signed(CW'(box_width));
    assign y1 = y0 + $signed(CW'(box_height));

    // strip edges
    assign xa = ox - bx;
    assign xb = ox + bx;
    assign xc = ox + tws - bx;
    assign xd = ox + tws + bx;
    assign ya = oy - by;
    assign yb = oy + by;
    assign yc = oy + ths - by;
    assign yd = oy + ths + by;

    // strict overlap against each strip
    assign top_hit    = (x0 < xd) && (x1 > xa) && (y0 < yb) && (y1 > ya);
    assign left_hit   = (x0 < xb) && (x1 > xa) && (y0 < yc) && (y1 > yb);
    assign right_hit  = (x0 < xd) && (x1 > xc) && (y0 < yc) && (y1 > yb);
    assign bottom_hit = (x0 < xd) && (x1 > xa) && (y0 < yd) && (y1 > yc);

    assign hit = top_hit || left_hit || right_hit || bottom_hit;

endmodule

`default_nettype wire

// ===== hw/rtl/tile_border_box_classifier.sv =====
`default_nettype none

// Tile border box classifier. Each input item is one bounding box found in a
// tile, with the tile's row and column; an item comes out (tile row, column
// and box index) only when the box strictly overlaps one of the four seam
// strips around its tile, otherwise the box is dropped. The block takes one
// item per clock while in_stall is low: one input register, the strip build
// and compare logic, and one result register, which drives the outputs;
// out_stall backs up into in_stall only when both registers are full. Tile
// geometry is set through the APB-style registers (byte address 4*i) and must
// be written only while no box is in flight; the block does not enforce this.
module tile_border_box_classifier
    import tbbc_pkg::*;
#(
    parameter int MAX_TILES_PER_AXIS = DEF_MAX_TILES_PER_AXIS,
    parameter int MAX_BOXES_PER_TILE = DEF_MAX_BOXES_PER_TILE,
    localparam int TILE_IDX_W = (MAX_TILES_PER_AXIS > 1) ? $clog2(MAX_TILES_PER_AXIS) : 1,
    localparam int COUNT_W    = $clog2(MAX_TILES_PER_AXIS + 1),
    localparam int IDX_W      = (MAX_BOXES_PER_TILE > 1) ? $clog2(MAX_BOXES_PER_TILE) : 1
)
(
    input  wire logic                       clk,
    input  wire logic                       rst_n,

    // configuration port
    input  wire logic                       psel,
    input  wire logic                       penable,
    input  wire logic                       pwrite,
    input  wire logic [APB_ADDR_W-1:0]      paddr,
    input  wire logic [APB_DATA_W-1:0]      pwdata,
    output logic      [APB_DATA_W-1:0]      prdata,
    output logic                            pready,

    // box items in
    input  wire logic                       in_valid,
    output logic                            in_stall,
    input  wire logic [TILE_IDX_W-1:0]      tile_row,
    input  wire logic [TILE_IDX_W-1:0]      tile_col,
    input  wire logic signed [COORD_W-1:0]  box_x,
    input  wire logic signed [COORD_W-1:0]  box_y,
    input  wire logic [EXTENT_W-1:0]        box_width,
    input  wire logic [EXTENT_W-1:0]        box_height,
    input  wire logic [IDX_W-1:0]           box_index,

    // seam hit items out
    output logic                            out_valid,
    input  wire logic                       out_stall,
    output logic [TILE_IDX_W-1:0]           hit_row,
    output logic [TILE_IDX_W-1:0]           hit_col,
    output logic [IDX_W-1:0]                hit_index
);

    // configuration registers
    tbbc_geom_t         geom_reg;
    logic [COUNT_W-1:0] tiles_across_reg;
    logic [COUNT_W-1:0] tiles_down_reg;
    logic               cfg_write;
    tbbc_reg_t          cfg_sel;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign cfg_sel   = tbbc_reg_t'(paddr[APB_ADDR_W-1:2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            geom_reg.seam_half_x     <= RST_BORDER;
            geom_reg.seam_half_y     <= RST_BORDER;
            geom_reg.tile_width      <= RST_SIZE;
            geom_reg.tile_height     <= RST_SIZE;
            geom_reg.last_col_width  <= RST_SIZE;
            geom_reg.last_row_height <= RST_SIZE;
            tiles_across_reg         <= COUNT_W'(RST_COUNT);
            tiles_down_reg           <= COUNT_W'(RST_COUNT);
        end
        else if (cfg_write)
        begin
            case (cfg_sel)
                REG_SEAM_HALF_X:     geom_reg.seam_half_x     <= pwdata[BORDER_W-1:0];
                REG_SEAM_HALF_Y:     geom_reg.seam_half_y     <= pwdata[BORDER_W-1:0];
                REG_TILE_WIDTH:      geom_reg.tile_width      <= pwdata[SIZE_W-1:0];
                REG_TILE_HEIGHT:     geom_reg.tile_height     <= pwdata[SIZE_W-1:0];
                REG_LAST_COL_WIDTH:  geom_reg.last_col_width  <= pwdata[SIZE_W-1:0];
                REG_LAST_ROW_HEIGHT: geom_reg.last_row_height <= pwdata[SIZE_W-1:0];
                REG_TILES_ACROSS:    tiles_across_reg         <= pwdata[COUNT_W-1:0];
                REG_TILES_DOWN:      tiles_down_reg           <= pwdata[COUNT_W-1:0];
                default:             ;
            endcase
        end
    end

    // register readback
    always_comb
    begin
        case (cfg_sel)
            REG_SEAM_HALF_X:     prdata = APB_DATA_W'(geom_reg.seam_half_x);
            REG_SEAM_HALF_Y:     prdata = APB_DATA_W'(geom_reg.seam_half_y);
            REG_TILE_WIDTH:      prdata = APB_DATA_W'(geom_reg.tile_width);
            REG_TILE_HEIGHT:     prdata = APB_DATA_W'(geom_reg.tile_height);
            REG_LAST_COL_WIDTH:  prdata = APB_DATA_W'(geom_reg.last_col_width);
            REG_LAST_ROW_HEIGHT: prdata = APB_DATA_W'(geom_reg.last_row_height);
            REG_TILES_ACROSS:    prdata = APB_DATA_W'(tiles_across_reg);
            REG_TILES_DOWN:      prdata = APB_DATA_W'(tiles_down_reg);
            default:             prdata = '0;
        endcase
    end

    // input register
    logic                      s1_valid_reg;
    logic [TILE_IDX_W-1:0]     s1_row_reg, s1_col_reg;
    logic signed [COORD_W-1:0] s1_x_reg, s1_y_reg;
    logic [EXTENT_W-1:0]       s1_w_reg, s1_h_reg;
    logic [IDX_W-1:0]          s1_index_reg;

    // result register
    logic                      s2_valid_reg;
    logic [TILE_IDX_W-1:0]     s2_row_reg, s2_col_reg;
    logic [IDX_W-1:0]          s2_index_reg;

    logic s2_free, s1_hit, s2_load;

    assign s2_free  = !s2_valid_reg || !out_stall;
    assign in_stall = s1_valid_reg && !s2_free;
    assign s2_load  = s2_free && s1_valid_reg && s1_hit;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            if (!in_stall)
            begin
                s1_valid_reg <= in_valid;
            end
            if (s2_free)
            begin
                s2_valid_reg <= s1_valid_reg && s1_hit;
            end
        end
    end

    // payload, no reset
    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            s1_row_reg   <= tile_row;
            s1_col_reg   <= tile_col;
            s1_x_reg     <= box_x;
            s1_y_reg     <= box_y;
            s1_w_reg     <= box_width;
            s1_h_reg     <= box_height;
            s1_index_reg <= box_index;
        end
        if (s2_load)
        begin
            s2_row_reg   <= s1_row_reg;
            s2_col_reg   <= s1_col_reg;
            s2_index_reg <= s1_index_reg;
        end
    end

    // strip build and overlap test
    tbbc_seam_check #(
        .TILE_IDX_W (TILE_IDX_W),
        .COUNT_W    (COUNT_W)
    ) u_seam_check (
        .geom         (geom_reg),
        .tiles_across (tiles_across_reg),
        .tiles_down   (tiles_down_reg),
        .tile_row     (s1_row_reg),
        .tile_col     (s1_col_reg),
        .box_x        (s1_x_reg),
        .box_y        (s1_y_reg),
        .box_width    (s1_w_reg),
        .box_height   (s1_h_reg),
        .hit          (s1_hit)
    );

    assign out_valid = s2_valid_reg;
    assign hit_row   = s2_row_reg;
    assign hit_col   = s2_col_reg;
    assign hit_index = s2_index_reg;

endmodule

`default_nettype wire
